// File: design/rv32e_pkg.sv
package rv32e_pkg;

	// mnemonic codes, real table entries first, then the pseudo-instructions
	typedef enum logic [5:0] {
		ACT_ADD, ACT_SUB, ACT_SLL, ACT_SLT, ACT_SLTU, ACT_XOR, ACT_SRL, ACT_SRA,
		ACT_OR, ACT_AND,
		ACT_MUL, ACT_MULH, ACT_MULHSU, ACT_MULHU, ACT_DIV, ACT_DIVU, ACT_REM,
		ACT_REMU,
		ACT_ADDI, ACT_SLTI, ACT_SLTIU, ACT_XORI, ACT_ORI, ACT_ANDI,
		ACT_SLLI, ACT_SRLI, ACT_SRAI,
		ACT_LB, ACT_LH, ACT_LW, ACT_LBU, ACT_LHU,
		ACT_SB, ACT_SH, ACT_SW,
		ACT_BEQ, ACT_BNE, ACT_BLT, ACT_BGE, ACT_BLTU, ACT_BGEU,
		ACT_LUI, ACT_AUIPC, ACT_JAL, ACT_JALR,
		ACT_FENCE, ACT_ECALL, ACT_EBREAK,
		ACT_LA, ACT_LI, ACT_J, ACT_MV, ACT_CALL, ACT_NOP,
		ACT_BLE, ACT_BGT, ACT_BLEU, ACT_BGTU
	} action_t;

	// first pseudo-instruction code, everything below is a real table entry
	localparam logic [5:0] ACT_FIRST_PSEUDO = 6'(ACT_LA);

	typedef enum logic [3:0] {
		FMT_R, FMT_I, FMT_SH, FMT_LD, FMT_ST, FMT_B, FMT_U, FMT_J, FMT_JR, FMT_SYS
	} fmt_t;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_UNKNOWN = 3'd1;
	localparam logic [2:0] ERR_IMM     = 3'd2;
	localparam logic [2:0] ERR_SHIFT   = 3'd3;
	localparam logic [2:0] ERR_BRANCH  = 3'd4;
	localparam logic [2:0] ERR_JAL     = 3'd5;
	localparam logic [2:0] ERR_ODD     = 3'd6;

	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_FENCE  = 7'h0F;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [6:0] F7_MUL  = 7'h01;

	localparam logic [11:0] FIX_NONE   = 12'h000;
	localparam logic [11:0] FIX_FENCE  = 12'h0FF;
	localparam logic [11:0] FIX_EBREAK = 12'h001;

	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [4:0] REG_RA   = 5'd1;

	// rounding bias for the hi/lo split
	localparam logic [31:0] HI_BIAS = 32'h0000_0800;

	typedef struct packed {
		fmt_t        fmt;
		logic [6:0]  opc;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [11:0] fix;
	} op_row_t;

	function automatic op_row_t op_row(input logic [5:0] code);
		op_row_t r;
		case (code)
			ACT_ADD:    r = '{FMT_R, OPC_OP, 3'd0, F7_BASE, FIX_NONE};
			ACT_SUB:    r = '{FMT_R, OPC_OP, 3'd0, F7_ALT, FIX_NONE};
			ACT_SLL:    r = '{FMT_R, OPC_OP, 3'd1, F7_BASE, FIX_NONE};
			ACT_SLT:    r = '{FMT_R, OPC_OP, 3'd2, F7_BASE, FIX_NONE};
			ACT_SLTU:   r = '{FMT_R, OPC_OP, 3'd3, F7_BASE, FIX_NONE};
			ACT_XOR:    r = '{FMT_R, OPC_OP, 3'd4, F7_BASE, FIX_NONE};
			ACT_SRL:    r = '{FMT_R, OPC_OP, 3'd5, F7_BASE, FIX_NONE};
			ACT_SRA:    r = '{FMT_R, OPC_OP, 3'd5, F7_ALT, FIX_NONE};
			ACT_OR:     r = '{FMT_R, OPC_OP, 3'd6, F7_BASE, FIX_NONE};
			ACT_AND:    r = '{FMT_R, OPC_OP, 3'd7, F7_BASE, FIX_NONE};
			ACT_MUL:    r = '{FMT_R, OPC_OP, 3'd0, F7_MUL, FIX_NONE};
			ACT_MULH:   r = '{FMT_R, OPC_OP, 3'd1, F7_MUL, FIX_NONE};
			ACT_MULHSU: r = '{FMT_R, OPC_OP, 3'd2, F7_MUL, FIX_NONE};
			ACT_MULHU:  r = '{FMT_R, OPC_OP, 3'd3, F7_MUL, FIX_NONE};
			ACT_DIV:    r = '{FMT_R, OPC_OP, 3'd4, F7_MUL, FIX_NONE};
			ACT_DIVU:   r = '{FMT_R, OPC_OP, 3'd5, F7_MUL, FIX_NONE};
			ACT_REM:    r = '{FMT_R, OPC_OP, 3'd6, F7_MUL, FIX_NONE};
			ACT_REMU:   r = '{FMT_R, OPC_OP, 3'd7, F7_MUL, FIX_NONE};
			ACT_ADDI:   r = '{FMT_I, OPC_OPIMM, 3'd0, F7_BASE, FIX_NONE};
			ACT_SLTI:   r = '{FMT_I, OPC_OPIMM, 3'd2, F7_BASE, FIX_NONE};
			ACT_SLTIU:  r = '{FMT_I, OPC_OPIMM, 3'd3, F7_BASE, FIX_NONE};
			ACT_XORI:   r = '{FMT_I, OPC_OPIMM, 3'd4, F7_BASE, FIX_NONE};
			ACT_ORI:    r = '{FMT_I, OPC_OPIMM, 3'd6, F7_BASE, FIX_NONE};
			ACT_ANDI:   r = '{FMT_I, OPC_OPIMM, 3'd7, F7_BASE, FIX_NONE};
			ACT_SLLI:   r = '{FMT_SH, OPC_OPIMM, 3'd1, F7_BASE, FIX_NONE};
			ACT_SRLI:   r = '{FMT_SH, OPC_OPIMM, 3'd5, F7_BASE, FIX_NONE};
			ACT_SRAI:   r = '{FMT_SH, OPC_OPIMM, 3'd5, F7_ALT, FIX_NONE};
			ACT_LB:     r = '{FMT_LD, OPC_LOAD, 3'd0, F7_BASE, FIX_NONE};
			ACT_LH:     r = '{FMT_LD, OPC_LOAD, 3'd1, F7_BASE, FIX_NONE};
			ACT_LW:     r = '{FMT_LD, OPC_LOAD, 3'd2, F7_BASE, FIX_NONE};
			ACT_LBU:    r = '{FMT_LD, OPC_LOAD, 3'd4, F7_BASE, FIX_NONE};
			ACT_LHU:    r = '{FMT_LD, OPC_LOAD, 3'd5, F7_BASE, FIX_NONE};
			ACT_SB:     r = '{FMT_ST, OPC_STORE, 3'd0, F7_BASE, FIX_NONE};
			ACT_SH:     r = '{FMT_ST, OPC_STORE, 3'd1, F7_BASE, FIX_NONE};
			ACT_SW:     r = '{FMT_ST, OPC_STORE, 3'd2, F7_BASE, FIX_NONE};
			ACT_BEQ:    r = '{FMT_B, OPC_BRANCH, 3'd0, F7_BASE, FIX_NONE};
			ACT_BNE:    r = '{FMT_B, OPC_BRANCH, 3'd1, F7_BASE, FIX_NONE};
			ACT_BLT:    r = '{FMT_B, OPC_BRANCH, 3'd4, F7_BASE, FIX_NONE};
			ACT_BGE:    r = '{FMT_B, OPC_BRANCH, 3'd5, F7_BASE, FIX_NONE};
			ACT_BLTU:   r = '{FMT_B, OPC_BRANCH, 3'd6, F7_BASE, FIX_NONE};
			ACT_BGEU:   r = '{FMT_B, OPC_BRANCH, 3'd7, F7_BASE, FIX_NONE};
			ACT_LUI:    r = '{FMT_U, OPC_LUI, 3'd0, F7_BASE, FIX_NONE};
			ACT_AUIPC:  r = '{FMT_U, OPC_AUIPC, 3'd0, F7_BASE, FIX_NONE};
			ACT_JAL:    r = '{FMT_J, OPC_JAL, 3'd0, F7_BASE, FIX_NONE};
			ACT_JALR:   r = '{FMT_JR, OPC_JALR, 3'd0, F7_BASE, FIX_NONE};
			ACT_FENCE:  r = '{FMT_SYS, OPC_FENCE, 3'd0, F7_BASE, FIX_FENCE};
			ACT_ECALL:  r = '{FMT_SYS, OPC_SYSTEM, 3'd0, F7_BASE, FIX_NONE};
			ACT_EBREAK: r = '{FMT_SYS, OPC_SYSTEM, 3'd0, F7_BASE, FIX_EBREAK};
			default:    r = '{FMT_SYS, OPC_FENCE, 3'd0, F7_BASE, FIX_NONE};
		endcase
		return r;
	endfunction

	// field packing for one real table entry
	function automatic logic [31:0] pack_word(
		input logic [5:0]  code,
		input logic [4:0]  rd,
		input logic [4:0]  rs1,
		input logic [4:0]  rs2,
		input logic [31:0] imm,
		input logic [31:0] off
	);
		op_row_t r;
		logic [31:0] w;
		r = op_row(code);
		case (r.fmt)
			FMT_R:
				w = {r.f7, rs2, rs1, r.f3, rd, r.opc};
			FMT_SH:
				w = {r.f7, imm[4:0], rs1, r.f3, rd, r.opc};
			FMT_SYS:
				w = {r.fix, 13'd0, r.opc};
			FMT_ST:
				w = {imm[11:5], rs2, rs1, r.f3, imm[4:0], r.opc};
			FMT_B:
				w = {off[12], off[10:5], rs2, rs1, r.f3, off[4:1], off[11], r.opc};
			FMT_U:
				w = {imm[19:0], rd, r.opc};
			FMT_J:
				w = {off[20], off[10:1], off[11], off[19:12], rd, r.opc};
			default:
				w = {imm[11:0], rs1, r.f3, rd, r.opc};
		endcase
		return w;
	endfunction

endpackage

// File: design/rv32im_instruction_encoder_core.sv
// rv32im instruction encoder
// request channel: req_valid/req_ready carry one parsed assembly operation
// (action code, register numbers, immediate, target address, location)
// response channel: rsp_valid/rsp_ready carry machine words, one per beat,
// with last set on the final word of an operation and error giving the
// reason when an operation is rejected (word then reads zero, last is set)
// timing: an accepted request is registered in the input stage, and its
// first word is then registered in the output register before it shows
// throughput: one request per cycle for single-word operations while
// rsp_ready is high; li with a wide immediate, la and call hold the input
// stage with the request until their second word goes out
// the output register lets a new request enter while the last word waits
// stall: when rsp_ready is low the output register holds its word, the
// input stage fills behind it and req_ready then drops
// reset: arst_n clears both valid flags, nothing is pending afterwards
module rv32im_instruction_encoder_core
	import rv32e_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [5:0]         action,
	input  logic [4:0]         dest_reg,
	input  logic [4:0]         src1_reg,
	input  logic [4:0]         src2_reg,
	input  logic signed [32:0] immediate,
	input  logic [31:0]        target_addr,
	input  logic [31:0]        location,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [31:0]        word,
	output logic               last,
	output logic [2:0]         error
);

	// input stage
	logic               valid_s1;
	logic               phase_s1;   // second word of a two-word expansion
	logic [5:0]         action_s1;
	logic [4:0]         rd_s1;
	logic [4:0]         rs1_s1;
	logic [4:0]         rs2_s1;
	logic signed [32:0] imm_s1;
	logic [31:0]        tgt_s1;
	logic [31:0]        loc_s1;

	// output stage
	logic        valid_s2;
	logic [31:0] word_s2;
	logic        last_s2;
	logic [2:0]  error_s2;

	// derived values
	logic [32:0] off_c;        // exact target minus location
	logic [31:0] ob_c;
	logic [31:0] off_round_c;  // offset plus the rounding bias
	logic [31:0] imm_round_c;  // immediate plus the rounding bias
	logic [31:0] hi_off_c;
	logic [31:0] hi_imm_c;
	logic [31:0] lo_off_c;
	logic [31:0] lo_imm_c;
	logic        imm_fits_c;   // -2048..2047
	logic        shamt_ok_c;   // 0..31
	logic        br_ok_c;      // -4096..4094 when even
	logic        jal_ok_c;     // -1048576..1048574 when even
	logic        odd_c;
	op_row_t     row_c;

	logic [31:0] w0_c;
	logic [31:0] w1_c;
	logic        two_c;
	logic [2:0]  err_c;

	// handshake
	logic load_s2;
	logic done_s1;

	assign off_c       = {1'b0, tgt_s1} - {1'b0, loc_s1};
	assign ob_c        = off_c[31:0];
	assign off_round_c = ob_c + HI_BIAS;
	assign imm_round_c = imm_s1[31:0] + HI_BIAS;
	// upper 20 bits land in the U-type immediate field
	assign hi_off_c    = {12'd0, off_round_c[31:12]};
	assign hi_imm_c    = {12'd0, imm_round_c[31:12]};
	assign lo_off_c    = {20'd0, ob_c[11:0]};
	assign lo_imm_c    = {20'd0, imm_s1[11:0]};

	// sign-extension checks: all bits above the field agree with its sign
	assign imm_fits_c  = (&imm_s1[32:11]) | ~(|imm_s1[32:11]);
	assign shamt_ok_c  = ~(|imm_s1[32:5]);
	assign br_ok_c     = (&off_c[32:13]) | ~(|off_c[32:13]);
	assign jal_ok_c    = (&off_c[32:20]) | ~(|off_c[32:20]);
	assign odd_c       = off_c[0];

	assign row_c = op_row(action_s1);

	// encoder: both words of the operation and its error code
	always_comb begin
		err_c = ERR_NONE;
		two_c = 1'b0;
		w0_c  = pack_word(action_s1, rd_s1, rs1_s1, rs2_s1, imm_s1[31:0], ob_c);
		w1_c  = '0;
		if (action_s1 < ACT_FIRST_PSEUDO) begin
			case (row_c.fmt) inside
				FMT_I, FMT_LD, FMT_ST, FMT_JR: begin
					if (!imm_fits_c)
						err_c = ERR_IMM;
				end
				FMT_SH: begin
					if (!shamt_ok_c)
						err_c = ERR_SHIFT;
				end
				FMT_B: begin
					if (odd_c)
						err_c = ERR_ODD;
					else if (!br_ok_c)
						err_c = ERR_BRANCH;
				end
				FMT_J: begin
					if (odd_c)
						err_c = ERR_ODD;
					else if (!jal_ok_c)
						err_c = ERR_JAL;
				end
				default: begin
					err_c = ERR_NONE;
				end
			endcase
		end else begin
			unique case (action_s1) inside
				ACT_LA: begin
					// auipc rd, hi then addi rd, rd, lo
					two_c = 1'b1;
					w0_c  = pack_word(ACT_AUIPC, rd_s1, REG_ZERO, REG_ZERO, hi_off_c, '0);
					w1_c  = pack_word(ACT_ADDI, rd_s1, rd_s1, REG_ZERO, lo_off_c, '0);
				end
				ACT_LI: begin
					if (imm_fits_c) begin
						w0_c = pack_word(ACT_ADDI, rd_s1, REG_ZERO, REG_ZERO,
							imm_s1[31:0], '0);
					end else begin
						two_c = 1'b1;
						w0_c  = pack_word(ACT_LUI, rd_s1, REG_ZERO, REG_ZERO,
							hi_imm_c, '0);
						w1_c  = pack_word(ACT_ADDI, rd_s1, rd_s1, REG_ZERO,
							lo_imm_c, '0);
					end
				end
				ACT_J: begin
					w0_c = pack_word(ACT_JAL, REG_ZERO, REG_ZERO, REG_ZERO, '0, ob_c);
					if (odd_c)
						err_c = ERR_ODD;
					else if (!jal_ok_c)
						err_c = ERR_JAL;
				end
				ACT_MV: begin
					w0_c = pack_word(ACT_ADDI, rd_s1, rs1_s1, REG_ZERO, '0, '0);
				end
				ACT_CALL: begin
					// auipc ra, hi then jalr ra, ra, lo
					two_c = 1'b1;
					w0_c  = pack_word(ACT_AUIPC, REG_RA, REG_ZERO, REG_ZERO, hi_off_c, '0);
					w1_c  = pack_word(ACT_JALR, REG_RA, REG_RA, REG_ZERO, lo_off_c, '0);
				end
				ACT_NOP: begin
					w0_c = pack_word(ACT_ADDI, REG_ZERO, REG_ZERO, REG_ZERO, '0, '0);
				end
				ACT_BLE, ACT_BGT, ACT_BLEU, ACT_BGTU: begin
					// reversed comparisons swap the source registers
					case (action_s1)
						ACT_BLE:  w0_c = pack_word(ACT_BGE, REG_ZERO, rs2_s1, rs1_s1,
							'0, ob_c);
						ACT_BGT:  w0_c = pack_word(ACT_BLT, REG_ZERO, rs2_s1, rs1_s1,
							'0, ob_c);
						ACT_BLEU: w0_c = pack_word(ACT_BGEU, REG_ZERO, rs2_s1, rs1_s1,
							'0, ob_c);
						default:  w0_c = pack_word(ACT_BLTU, REG_ZERO, rs2_s1, rs1_s1,
							'0, ob_c);
					endcase
					if (odd_c)
						err_c = ERR_ODD;
					else if (!br_ok_c)
						err_c = ERR_BRANCH;
				end
				default: begin
					err_c = ERR_UNKNOWN;
				end
			endcase
		end
	end

	// the output register takes a word whenever it is empty or being drained
	assign load_s2   = valid_s1 && (!valid_s2 || rsp_ready);
	// an errored operation is a single beat even if it would have expanded
	assign done_s1   = load_s2 && (phase_s1 || !two_c || (err_c != ERR_NONE));
	assign req_ready = !valid_s1 || done_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				valid_s1 <= 1'b1;
				phase_s1 <= 1'b0;
			end else if (done_s1) begin
				valid_s1 <= 1'b0;
				phase_s1 <= 1'b0;
			end else if (load_s2) begin
				phase_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			action_s1 <= action;
			rd_s1     <= dest_reg;
			rs1_s1    <= src1_reg;
			rs2_s1    <= src2_reg;
			imm_s1    <= immediate;
			tgt_s1    <= target_addr;
			loc_s1    <= location;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			if (load_s2)
				valid_s2 <= 1'b1;
			else if (rsp_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			if (phase_s1) begin
				word_s2  <= w1_c;
				last_s2  <= 1'b1;
				error_s2 <= ERR_NONE;
			end else if (err_c != ERR_NONE) begin
				word_s2  <= '0;
				last_s2  <= 1'b1;
				error_s2 <= err_c;
			end else begin
				word_s2  <= w0_c;
				last_s2  <= !two_c;
				error_s2 <= ERR_NONE;
			end
		end
	end

	assign rsp_valid = valid_s2;
	assign word      = word_s2;
	assign last      = last_s2;
	assign error     = error_s2;

endmodule
